// ===== sv/kclrd_pkg.sv =====
// ----------------------------------------------------------------------------
// kclrd_pkg
// shared constants and types for the key click / long / repeat detector
// ----------------------------------------------------------------------------
package kclrd_pkg;

    localparam int NUM_KEYS = 4;
    localparam int PIN_W    = 4;
    localparam int KEY_W    = 2;
    localparam int SEL_W    = 3;
    localparam int FLAGS_W  = 6;
    localparam int PERIOD_W = 8;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // flag select codes, also bit positions in the flag vector
    localparam logic [SEL_W-1:0] FLAG_HOLD   = 3'd0;
    localparam logic [SEL_W-1:0] FLAG_DOWN   = 3'd1;
    localparam logic [SEL_W-1:0] FLAG_UP     = 3'd2;
    localparam logic [SEL_W-1:0] FLAG_SINGLE = 3'd3;
    localparam logic [SEL_W-1:0] FLAG_LONG   = 3'd4;
    localparam logic [SEL_W-1:0] FLAG_REPEAT = 3'd5;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS = 2'd2;

    // per-key control, shared by all key lanes
    typedef struct packed {
        logic             tick;
        logic             sample;
        logic [SEL_W-1:0] sel;
    } t_key_ctrl;

endpackage

// ===== sv/key_click_long_repeat_detector_core.sv =====
// ----------------------------------------------------------------------------
// key_click_long_repeat_detector_core
// debounced key scanner with click, long-press and auto-repeat flags
// ----------------------------------------------------------------------------
// channel   | dir | fields
// s_axis    | in  | tdata: pin_levels, key_index, flag_select; tuser: req_type
// m_axis    | out | tdata: flag_set
// cfg       | in  | scan_period, long_press_ticks, repeat_ticks by index
//
// every transfer passes through the input register and then the result
// register; one transfer is taken per cycle while m_axis does not stall
// all key lanes update side by side in the cycle an item leaves the input register
// reset clears levels, phases, countdowns, flags and the sample divider, and
// loads the configuration defaults
// a stall on m_axis holds the result register; the input register then fills
// and s_axis_tready drops
// ----------------------------------------------------------------------------
module key_click_long_repeat_detector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [3:0] pin_levels, [5:4] key_index,
                                       // [8:6] flag_select, [15:9] zero
    input  logic        s_axis_tuser,  // [0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] flag_set, [7:1] zero
    // configuration writes
    input  logic                               i_cfg_wr_en,
    input  logic [kclrd_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [kclrd_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data
);
    import kclrd_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_scan_period;
    logic [TICKS_W-1:0]  r_long_ticks;
    logic [TICKS_W-1:0]  r_repeat_ticks;

    // input register
    logic             r_in_valid;
    logic             r_in_type;
    logic [PIN_W-1:0] r_in_pins;
    logic [KEY_W-1:0] r_in_key;
    logic [SEL_W-1:0] r_in_sel;

    // result register
    logic r_out_valid;
    logic r_out_flag;

    // sample divider
    logic [PERIOD_W-1:0] r_divider;
    logic [PERIOD_W-1:0] n_divider;
    logic [PERIOD_W-1:0] div_inc;

    logic                advance;
    logic                in_take;
    t_key_ctrl           ctrl;
    logic [NUM_KEYS-1:0] lane_flag;
    logic [NUM_KEYS-1:0] lane_down;
    logic [NUM_KEYS-1:0] lane_hit;
    logic                n_out_flag;

    // item moves from input to result register when the result slot frees
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_flag};

    // divider counts ticks, sample fires once it reaches the scan period
    assign div_inc     = r_divider + 1'b1;
    assign ctrl.tick   = (r_in_type == REQ_TICK);
    assign ctrl.sample = (div_inc >= r_scan_period);
    assign ctrl.sel    = r_in_sel;
    assign n_divider   = ctrl.tick ? (ctrl.sample ? '0 : div_inc) : r_divider;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_key
            // keys beyond the pin bus always read released
            if (k < PIN_W) begin : g_pin
                assign lane_down[k] = !r_in_pins[k];
            end else begin : g_nopin
                assign lane_down[k] = 1'b0;
            end
            assign lane_hit[k] = (r_in_type == REQ_CHECK) &&
                                 (32'(r_in_key) == k);

            kclrd_key u_key (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_en           (advance),
                .i_ctrl         (ctrl),
                .i_check        (lane_hit[k]),
                .i_pressed      (lane_down[k]),
                .i_long_ticks   (r_long_ticks),
                .i_repeat_ticks (r_repeat_ticks),
                .o_flag         (lane_flag[k])
            );
        end
    endgenerate

    // answer comes from the addressed key; ticks and absent keys answer zero
    assign n_out_flag = |(lane_flag & lane_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period  <= PERIOD_W'(10);
            r_long_ticks   <= TICKS_W'(1000);
            r_repeat_ticks <= TICKS_W'(200);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SCAN_PERIOD:  r_scan_period  <= i_cfg_wr_data[PERIOD_W-1:0];
                CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_wr_data[TICKS_W-1:0];
                CFG_REPEAT_TICKS: r_repeat_ticks <= i_cfg_wr_data[TICKS_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_divider   <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_divider   <= n_divider;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_type <= s_axis_tuser;
            r_in_pins <= s_axis_tdata[3:0];
            r_in_key  <= s_axis_tdata[5:4];
            r_in_sel  <= s_axis_tdata[8:6];
        end
        if (advance) begin
            r_out_flag <= n_out_flag;
        end
    end

endmodule

// ===== sv/kclrd_key.sv =====
// ----------------------------------------------------------------------------
// kclrd_key
// one key lane: level, countdown, press phase and sticky event flags
// ----------------------------------------------------------------------------
module kclrd_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  kclrd_pkg::t_key_ctrl          i_ctrl,
    input  logic                          i_check,
    input  logic                          i_pressed,
    input  logic [kclrd_pkg::TICKS_W-1:0] i_long_ticks,
    input  logic [kclrd_pkg::TICKS_W-1:0] i_repeat_ticks,
    output logic                          o_flag
);
    import kclrd_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_WAIT   = 2'd1;
    localparam logic [1:0] PH_REPEAT = 2'd2;

    logic               r_level;
    logic [1:0]         r_phase;
    logic [TICKS_W-1:0] r_count;
    logic [FLAGS_W-1:0] r_flags;

    logic               n_level;
    logic [1:0]         n_phase;
    logic [TICKS_W-1:0] n_count;
    logic [FLAGS_W-1:0] n_flags;
    logic               sel_ok;

    assign sel_ok = (i_ctrl.sel <= FLAG_REPEAT);
    assign o_flag = sel_ok ? r_flags[i_ctrl.sel] : 1'b0;

    always_comb begin
        n_level = r_level;
        n_phase = r_phase;
        n_count = r_count;
        n_flags = r_flags;
        if (i_ctrl.tick) begin
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
            if (i_ctrl.sample) begin
                n_level = i_pressed;
                n_flags[FLAG_HOLD] = i_pressed;
                if (i_pressed && !r_level) begin
                    n_flags[FLAG_DOWN] = 1'b1;
                end
                if (!i_pressed && r_level) begin
                    n_flags[FLAG_UP] = 1'b1;
                end
                unique case (r_phase)
                    PH_WAIT: begin
                        if (!i_pressed) begin
                            n_flags[FLAG_SINGLE] = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (n_count == '0) begin
                            n_flags[FLAG_LONG] = 1'b1;
                            n_count = i_repeat_ticks;
                            n_phase = PH_REPEAT;
                        end
                    end
                    PH_REPEAT: begin
                        if (!i_pressed) begin
                            n_phase = PH_IDLE;
                        end else if (n_count == '0) begin
                            n_flags[FLAG_REPEAT] = 1'b1;
                            n_count = i_repeat_ticks;
                        end
                    end
                    default: begin
                        // idle, and the unused code behaves as idle
                        if (i_pressed) begin
                            n_count = i_long_ticks;
                            n_phase = PH_WAIT;
                        end
                    end
                endcase
            end
        end else if (i_check && sel_ok && i_ctrl.sel != FLAG_HOLD) begin
            n_flags[i_ctrl.sel] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_flags <= '0;
        end else if (i_en) begin
            r_level <= n_level;
            r_phase <= n_phase;
            r_count <= n_count;
            r_flags <= n_flags;
        end
    end

endmodule
